// File: rtl/fdda_pkg.sv
// ----------------------------------------------------------------------------
// fdda_pkg: shared types and constants of the demixing accumulator
// Field widths, store geometry and the word types that pass between modules.
// ----------------------------------------------------------------------------
package fdda_pkg;

  localparam int NUM_BINS = 512;
  localparam int ADDR_W   = $clog2(NUM_BINS);

  localparam int SRC_W  = 2;
  localparam int BIN_W  = 9;
  localparam int SMP_W  = 16;
  localparam int PROD_W = 2 * SMP_W;
  localparam int TERM_W = PROD_W + 1;
  localparam int ACC_W  = 40;

  typedef logic        [SRC_W-1:0]  src_t;
  typedef logic        [BIN_W-1:0]  bin_t;
  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Control fields that travel with an item down the pipeline.
  typedef struct packed {
    src_t src;
    bin_t bin;
    logic first;
    logic last;
    logic active;
    logic mask;
  } ctl_t;

  // One store word: the real and imaginary accumulators of a bin.
  typedef struct packed {
    acc_t re;
    acc_t im;
  } acc_pair_t;

endpackage

// File: rtl/fdda_if.sv
// ----------------------------------------------------------------------------
// fdda_if: channel interfaces of the demixing accumulator
// Input beats carry one spectrum bin and weight; output beats one result bin.
// ----------------------------------------------------------------------------
interface fdda_in_if;
  import fdda_pkg::*;

  logic valid;
  logic ready;
  src_t source_index;
  bin_t bin_index;
  logic first_channel;
  logic last_channel;
  logic source_active;
  logic channel_mask;
  smp_t x_re;
  smp_t x_im;
  smp_t w_re;
  smp_t w_im;

  modport source (
    output valid, source_index, bin_index, first_channel, last_channel,
           source_active, channel_mask, x_re, x_im, w_re, w_im,
    input  ready
  );

  modport sink (
    input  valid, source_index, bin_index, first_channel, last_channel,
           source_active, channel_mask, x_re, x_im, w_re, w_im,
    output ready
  );
endinterface

interface fdda_out_if;
  import fdda_pkg::*;

  logic valid;
  logic ready;
  src_t out_source;
  bin_t out_bin;
  acc_t y_re;
  acc_t y_im;

  modport source (
    output valid, out_source, out_bin, y_re, y_im,
    input  ready
  );

  modport sink (
    input  valid, out_source, out_bin, y_re, y_im,
    output ready
  );
endinterface

// File: rtl/fdda_ram.sv
// ----------------------------------------------------------------------------
// fdda_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/fdda_cmul.sv
// ----------------------------------------------------------------------------
// fdda_cmul: two-stage complex multiplier
// Registers the four partial products, then the real and imaginary terms.
// ----------------------------------------------------------------------------
module fdda_cmul (
  input  logic           clk,
  input  logic           en,
  input  fdda_pkg::smp_t x_re,
  input  fdda_pkg::smp_t x_im,
  input  fdda_pkg::smp_t w_re,
  input  fdda_pkg::smp_t w_im,
  output fdda_pkg::term_t t_re,
  output fdda_pkg::term_t t_im
);
  import fdda_pkg::*;

  logic signed [PROD_W-1:0] p_rr_r;
  logic signed [PROD_W-1:0] p_ii_r;
  logic signed [PROD_W-1:0] p_ri_r;
  logic signed [PROD_W-1:0] p_ir_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r <= w_re * x_re;
      p_ii_r <= w_im * x_im;
      p_ri_r <= w_re * x_im;
      p_ir_r <= w_im * x_re;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_re <= {p_rr_r[PROD_W-1], p_rr_r} - {p_ii_r[PROD_W-1], p_ii_r};
      t_im <= {p_ri_r[PROD_W-1], p_ri_r} + {p_ir_r[PROD_W-1], p_ir_r};
    end
  end

endmodule

// File: rtl/freq_domain_demix_accumulator_unit.sv
// ----------------------------------------------------------------------------
// freq_domain_demix_accumulator_unit: frequency-domain demixing accumulator
// Multiplies each channel bin by its demixing weight and sums the products
// per bin in a bin-addressed store, emitting the sum on the last channel.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake          Payload
//  --------  ----  -----------------  ----------------------------------------
//  in_bus    in    valid/ready beat   source, bin, first/last, active, mask,
//                                     x (Q1.15 complex), w (Q1.15 complex)
//  out_bus   out   valid/ready beat   source, bin, y (Q10.30 complex)
//
// One beat is accepted per cycle while the pipeline advances. A result
// passes through stage A, stage B, stage C and the output register; the
// depth is set by the registered store read in parallel with the two multiplier stages.
// Reset is synchronous and clears only the pipeline valid bits, the
// forwarding history valid bits and the output valid bit; the store is not cleared.
// The whole pipeline advances together and stalls only while a result sits
// in the output register and the sink does not take it.
//
module freq_domain_demix_accumulator_unit (
  input logic       clk,
  input logic       rst_n,
  fdda_in_if.sink   in_bus,
  fdda_out_if.source out_bus
);
  import fdda_pkg::*;

  // The last two writes can land after a later beat has read the store, so
  // they are kept here and override the stale read data.
  localparam int HIST_D = 2;

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_acc;
  logic out_valid_r;
  logic out_valid_nxt;

  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;
  assign in_acc       = in_bus.valid && adv;

  // ---------------------------------------------------------------------------
  // Stage A: input register; the store read is issued from here.
  // ---------------------------------------------------------------------------
  logic a_vld_r;
  ctl_t a_ctl_r;
  smp_t a_xr_r;
  smp_t a_xi_r;
  smp_t a_wr_r;
  smp_t a_wi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ctl_r.src    <= in_bus.source_index;
      a_ctl_r.bin    <= in_bus.bin_index;
      a_ctl_r.first  <= in_bus.first_channel;
      a_ctl_r.last   <= in_bus.last_channel;
      a_ctl_r.active <= in_bus.source_active;
      a_ctl_r.mask   <= in_bus.channel_mask;
      a_xr_r         <= in_bus.x_re;
      a_xi_r         <= in_bus.x_im;
      a_wr_r         <= in_bus.w_re;
      a_wi_r         <= in_bus.w_im;
    end
  end

  // A masked channel contributes zero, so its sample is forced to zero.
  smp_t    mul_xr;
  smp_t    mul_xi;
  term_t   t_re;
  term_t   t_im;

  assign mul_xr = a_ctl_r.mask ? a_xr_r : '0;
  assign mul_xi = a_ctl_r.mask ? a_xi_r : '0;

  fdda_cmul u_cmul (
    .clk  (clk),
    .en   (adv),
    .x_re (mul_xr),
    .x_im (mul_xi),
    .w_re (a_wr_r),
    .w_im (a_wi_r),
    .t_re (t_re),
    .t_im (t_im)
  );

  // ---------------------------------------------------------------------------
  // Accumulator store
  // ---------------------------------------------------------------------------
  logic                   wr_en;
  logic      [ADDR_W-1:0] wr_addr;
  acc_pair_t              acc_new;
  acc_pair_t              rd_data;

  fdda_ram #(
    .WIDTH ($bits(acc_pair_t)),
    .DEPTH (NUM_BINS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (acc_new),
    .rd_en   (adv),
    .rd_addr (a_ctl_r.bin[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Stage B: products in flight, store read data arrives.
  // ---------------------------------------------------------------------------
  logic b_vld_r;
  ctl_t b_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ctl_r <= a_ctl_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: terms ready; accumulate, write back and load the result.
  // ---------------------------------------------------------------------------
  logic      c_vld_r;
  ctl_t      c_ctl_r;
  acc_pair_t c_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ctl_r  <= b_ctl_r;
      c_base_r <= rd_data;
    end
  end

  // Bins beyond the store do not write it and report zero.
  logic c_in_range;
  assign c_in_range = ({1'b0, c_ctl_r.bin} < (BIN_W + 1)'(NUM_BINS));

  // Forwarding history of the most recent writes, index 0 newest.
  logic                  hist_vld_r [HIST_D];
  logic     [ADDR_W-1:0] hist_addr_r [HIST_D];
  acc_pair_t             hist_val_r [HIST_D];

  acc_pair_t base_fwd;
  acc_pair_t base;

  always_comb begin
    base_fwd = c_base_r;
    for (int i = HIST_D - 1; i >= 0; i--) begin
      if (hist_vld_r[i] && (hist_addr_r[i] == wr_addr)) begin
        base_fwd = hist_val_r[i];
      end
    end
    base = c_ctl_r.first ? '0 : base_fwd;
  end

  assign wr_addr    = c_ctl_r.bin[ADDR_W-1:0];
  assign acc_new.re = base.re + {{(ACC_W - TERM_W){t_re[TERM_W-1]}}, t_re};
  assign acc_new.im = base.im + {{(ACC_W - TERM_W){t_im[TERM_W-1]}}, t_im};
  assign wr_en      = adv && c_vld_r && c_in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_D; i++) begin
        hist_vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      hist_vld_r[0] <= 1'b1;
      for (int i = 1; i < HIST_D; i++) begin
        hist_vld_r[i] <= hist_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_addr_r[0] <= wr_addr;
      hist_val_r[0]  <= acc_new;
      for (int i = 1; i < HIST_D; i++) begin
        hist_addr_r[i] <= hist_addr_r[i-1];
        hist_val_r[i]  <= hist_val_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  src_t out_src_r;
  bin_t out_bin_r;
  acc_t y_re_r;
  acc_t y_im_r;

  assign out_valid_nxt = adv ? (c_vld_r && c_ctl_r.last) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // An inactive source still updates the store but reports zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_src_r <= c_ctl_r.src;
      out_bin_r <= c_ctl_r.bin;
      if (c_ctl_r.active && c_in_range) begin
        y_re_r <= acc_new.re;
        y_im_r <= acc_new.im;
      end else begin
        y_re_r <= '0;
        y_im_r <= '0;
      end
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_source = out_src_r;
  assign out_bus.out_bin    = out_bin_r;
  assign out_bus.y_re       = y_re_r;
  assign out_bus.y_im       = y_im_r;

endmodule

// File: rtl/fdda_chk.sv
// ----------------------------------------------------------------------------
// fdda_chk: port-level checks of the demixing accumulator
// Watches the handshakes on both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module fdda_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A result held back by the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // The block only pushes back while a result waits in the output register.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // With nothing accepted and nothing offered over the window below the
  // pipeline is drained, so no result may appear out of nowhere.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !in_acc) ##1 (!out_valid && !in_acc) ##1
    (!out_valid && !in_acc) ##1 (!out_valid && !in_acc) |=> !out_valid)
    else $error("result beat without a matching input beat");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat offered right after reset");

endmodule

bind freq_domain_demix_accumulator_unit fdda_chk u_fdda_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready)
);

// File: tb/fdda_demix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdda_demix_checker: separated-bin predictor and comparator
// Watches both channels of the demixing accumulator, keeps its own per-bin
// complex sums, and compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module fdda_demix_checker (
  input  logic clk,
  input  logic rst_n,
  fdda_in_if   in_mon,
  fdda_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   beats_seen,
  output int   bins_checked,
  output int   silent_bins
);
  import fdda_pkg::*;

  typedef struct packed {
    src_t src;
    bin_t bin;
    acc_t re;
    acc_t im;
  } separated_bin_t;

  acc_t           bin_re_sum [NUM_BINS];
  acc_t           bin_im_sum [NUM_BINS];
  separated_bin_t expected_bins [$];
  int             mismatches = 0;
  int             n_beats = 0;
  int             n_bins = 0;
  int             n_silent = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Complex multiply-accumulate of one accepted beat into the bin sums.
  task automatic absorb_beat();
    longint         prod_re;
    longint         prod_im;
    acc_t           base_re;
    acc_t           base_im;
    separated_bin_t due;
    prod_re = 0;
    prod_im = 0;
    n_beats++;
    if (in_mon.channel_mask) begin
      prod_re = longint'(in_mon.w_re) * longint'(in_mon.x_re)
              - longint'(in_mon.w_im) * longint'(in_mon.x_im);
      prod_im = longint'(in_mon.w_re) * longint'(in_mon.x_im)
              + longint'(in_mon.w_im) * longint'(in_mon.x_re);
    end
    base_re = in_mon.first_channel ? acc_t'(0) : bin_re_sum[in_mon.bin_index];
    base_im = in_mon.first_channel ? acc_t'(0) : bin_im_sum[in_mon.bin_index];
    bin_re_sum[in_mon.bin_index] = acc_t'(base_re + prod_re);
    bin_im_sum[in_mon.bin_index] = acc_t'(base_im + prod_im);
    if (in_mon.last_channel) begin
      due.src = in_mon.source_index;
      due.bin = in_mon.bin_index;
      due.re  = bin_re_sum[in_mon.bin_index];
      due.im  = bin_im_sum[in_mon.bin_index];
      // A silent source still updates the store but reports zeros.
      if (!in_mon.source_active) begin
        due.re = '0;
        due.im = '0;
        n_silent++;
      end
      expected_bins.push_back(due);
    end
  endtask

  task automatic check_result();
    separated_bin_t due;
    if (expected_bins.size() == 0) begin
      report_mismatch($sformatf("result source %0d bin %0d arrived with none pending",
                                out_mon.out_source, out_mon.out_bin));
    end else begin
      due = expected_bins.pop_front();
      n_bins++;
      if (out_mon.out_source !== due.src) begin
        report_mismatch($sformatf("bin %0d: source %0d, expected %0d",
                                  due.bin, out_mon.out_source, due.src));
      end
      if (out_mon.out_bin !== due.bin) begin
        report_mismatch($sformatf("bin %0d reported as bin %0d", due.bin, out_mon.out_bin));
      end
      if (out_mon.y_re !== due.re) begin
        report_mismatch($sformatf("bin %0d: y_re %0d, expected %0d",
                                  due.bin, out_mon.y_re, due.re));
      end
      if (out_mon.y_im !== due.im) begin
        report_mismatch($sformatf("bin %0d: y_im %0d, expected %0d",
                                  due.bin, out_mon.y_im, due.im));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        absorb_beat();
      end
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
    end
    fail_count   <= mismatches;
    pending      <= expected_bins.size();
    beats_seen   <= n_beats;
    bins_checked <= n_bins;
    silent_bins  <= n_silent;
  end

endmodule

// File: tb/freq_domain_demix_accumulator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freq_domain_demix_accumulator_unit_tb: stimulus and verdict for the demixer
// Drives directed corner beats, then random source/channel/bin frames mixed
// with loose beats, under three flow-control regimes and a long sink stall.
// ----------------------------------------------------------------------------
module freq_domain_demix_accumulator_unit_tb;
  import fdda_pkg::*;

  // The limit is well above the slowest legal run.
  localparam int   RUN_LIMIT_NS    = 2_400_000;
  localparam int   HOLD_OFF_CYCLES = 300;
  // Wait a little longer once every predicted result has been taken.
  localparam int   SETTLE_CYCLES   = 8;
  localparam int   BEATS_PER_PHASE = 150;
  localparam smp_t SMP_MIN         = 16'sh8000;
  localparam smp_t SMP_MAX         = 16'sh7fff;

  typedef struct packed {
    src_t src;
    bin_t bin;
    logic first;
    logic last;
    logic active;
    logic mask;
    smp_t xr;
    smp_t xi;
    smp_t wr;
    smp_t wi;
  } spectral_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  fdda_in_if  in_bus ();
  fdda_out_if out_bus ();

  int fail_count;
  int pending;
  int beats_seen;
  int bins_checked;
  int silent_bins;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_taken   = 0;
  int hold_left     = 0;
  int beats_sent    = 0;

  // Bins that some first-channel beat has written since reset. A beat that
  // continues an accumulation may only target one of these, since the store
  // holds garbage until written.
  bit   bin_written [NUM_BINS];
  bin_t written_bins [$];
  bin_t last_bin;

  freq_domain_demix_accumulator_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  fdda_demix_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .fail_count  (fail_count),
    .pending     (pending),
    .beats_seen  (beats_seen),
    .bins_checked(bins_checked),
    .silent_bins (silent_bins)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // Result sink. It takes results at a random rate, and when asked it refuses
  // everything for a long stretch so that the pipeline backs up into the
  // input channel while the sender keeps offering beats.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic spectral_beat_t make_beat(input src_t src, input bin_t bin,
                                               input logic first, input logic last,
                                               input logic active, input logic mask,
                                               input smp_t xr, input smp_t xi,
                                               input smp_t wr, input smp_t wi);
    spectral_beat_t b;
    b.src    = src;
    b.bin    = bin;
    b.first  = first;
    b.last   = last;
    b.active = active;
    b.mask   = mask;
    b.xr     = xr;
    b.xi     = xi;
    b.wr     = wr;
    b.wi     = wi;
    return b;
  endfunction

  // Mostly uniform samples, with the full-scale values and zero thrown in often.
  function automatic smp_t pick_sample();
    case ($urandom_range(9))
      0:       return SMP_MIN;
      1:       return SMP_MAX;
      2:       return '0;
      default: return smp_t'($urandom);
    endcase
  endfunction

  // Offer one beat, possibly after some idle cycles, and hold it until the
  // block takes it. Valid stays high into the next beat when no gap is drawn.
  task automatic send_beat(input spectral_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.source_index  <= b.src;
    in_bus.bin_index     <= b.bin;
    in_bus.first_channel <= b.first;
    in_bus.last_channel  <= b.last;
    in_bus.source_active <= b.active;
    in_bus.channel_mask  <= b.mask;
    in_bus.x_re          <= b.xr;
    in_bus.x_im          <= b.xi;
    in_bus.w_re          <= b.wr;
    in_bus.w_im          <= b.wi;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    beats_sent++;
    if (b.first && !bin_written[b.bin]) begin
      bin_written[b.bin] = 1'b1;
      written_bins.push_back(b.bin);
    end
    last_bin = b.bin;
  endtask

  // One source's worth of work: every channel in turn over the same set of
  // bins. An odd stride keeps the bins of a frame distinct. Now and then the
  // frame is cut short before its last channel, so no result comes out of it.
  task automatic send_frame();
    src_t src;
    bin_t start;
    bin_t stride;
    int   n_bins;
    int   n_chan;
    int   n_sent;
    logic active;
    src    = src_t'($urandom_range(3));
    start  = bin_t'($urandom);
    stride = bin_t'($urandom_range(255) * 2 + 1);
    n_bins = $urandom_range(6, 1);
    n_chan = ($urandom_range(7) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
    active = ($urandom_range(7) != 0);
    n_sent = n_chan;
    if (n_chan > 1 && $urandom_range(11) == 0) begin
      n_sent = $urandom_range(n_chan - 1, 1);
    end
    for (int ch = 0; ch < n_sent; ch++) begin
      for (int k = 0; k < n_bins; k++) begin
        send_beat(make_beat(src, bin_t'(start + k * stride), ch == 0, ch == n_chan - 1,
                            active, $urandom_range(4) != 0, pick_sample(), pick_sample(),
                            pick_sample(), pick_sample()));
      end
    end
  endtask

  // A loose beat with random flags. A third of them hit the bin of the beat
  // just before, so back-to-back updates of one bin get exercised.
  task automatic send_noise();
    spectral_beat_t b;
    b = make_beat(src_t'($urandom), bin_t'($urandom), $urandom_range(1) == 1,
                  $urandom_range(1) == 1, $urandom_range(3) != 0, $urandom_range(3) != 0,
                  smp_t'($urandom), smp_t'($urandom), smp_t'($urandom), smp_t'($urandom));
    if ($urandom_range(2) == 0) begin
      b.bin   = last_bin;
      b.first = 1'b0;
    end
    if (!b.first && !bin_written[b.bin]) begin
      if (written_bins.size() == 0) begin
        b.first = 1'b1;
      end else begin
        b.bin = written_bins[$urandom_range(written_bins.size() - 1)];
      end
    end
    send_beat(b);
  endtask

  task automatic send_random_until(input int target);
    while (beats_sent < target) begin
      if ($urandom_range(5) == 0) begin
        send_noise();
      end else begin
        send_frame();
      end
    end
  endtask

  // Stop offering beats until every predicted result has been taken.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // Full-scale operands: all four at the negative limit give a zero real
    // part and the largest imaginary part.
    send_beat(make_beat(2'd0, 9'd0, 1'b1, 1'b1, 1'b1, 1'b1,
                        SMP_MIN, SMP_MIN, SMP_MIN, SMP_MIN));
    // Largest positive real term, on the top bin.
    send_beat(make_beat(2'd1, 9'd511, 1'b1, 1'b1, 1'b1, 1'b1,
                        SMP_MIN, SMP_MAX, SMP_MIN, SMP_MIN));
    send_beat(make_beat(2'd1, 9'd256, 1'b1, 1'b1, 1'b1, 1'b1,
                        SMP_MAX, SMP_MIN, SMP_MAX, SMP_MAX));
    // Silent source: the store is written but the result is zero.
    send_beat(make_beat(2'd2, 9'd85, 1'b1, 1'b1, 1'b0, 1'b1,
                        SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
    // Masked channel on a first-and-last beat: the entry becomes zero.
    send_beat(make_beat(2'd3, 9'd170, 1'b1, 1'b1, 1'b1, 1'b0,
                        SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX));
    // Four channels over bins 4 and 5, interleaved. Bin 4 piles up the
    // largest positive term, bin 5 the most negative one, with channel 2
    // masked off on bin 5.
    for (int ch = 0; ch < 4; ch++) begin
      send_beat(make_beat(2'd3, 9'd4, ch == 0, ch == 3, 1'b1, 1'b1,
                          SMP_MIN, SMP_MAX, SMP_MIN, SMP_MIN));
      send_beat(make_beat(2'd3, 9'd5, ch == 0, ch == 3, 1'b1, ch != 2,
                          SMP_MAX, SMP_MIN, SMP_MIN, SMP_MIN));
    end
    // Keep accumulating on bin 4 after its last channel: once silent, then
    // active, so the silent beat's update must show up in the second result.
    send_beat(make_beat(2'd2, 9'd4, 1'b0, 1'b1, 1'b0, 1'b1,
                        SMP_MIN, SMP_MAX, SMP_MIN, SMP_MIN));
    send_beat(make_beat(2'd2, 9'd4, 1'b0, 1'b1, 1'b1, 1'b1,
                        SMP_MIN, SMP_MAX, SMP_MIN, SMP_MIN));
    // Back-to-back beats on one bin, then an overwrite with a masked channel.
    send_beat(make_beat(2'd0, 9'd6, 1'b1, 1'b0, 1'b1, 1'b1,
                        16'sh1234, -16'sh4321, 16'sh7000, 16'sh0abc));
    send_beat(make_beat(2'd0, 9'd6, 1'b0, 1'b1, 1'b1, 1'b1,
                        -16'sh0f0f, 16'sh5a5a, -16'sh2000, 16'sh3fff));
    send_beat(make_beat(2'd0, 9'd6, 1'b1, 1'b1, 1'b1, 1'b0,
                        SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX));
  endtask

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.source_index  = '0;
    in_bus.bin_index     = '0;
    in_bus.first_channel = 1'b0;
    in_bus.last_channel  = 1'b0;
    in_bus.source_active = 1'b0;
    in_bus.channel_mask  = 1'b0;
    in_bus.x_re          = '0;
    in_bus.x_im          = '0;
    in_bus.w_re          = '0;
    in_bus.w_im          = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: a sender that rarely pauses against a sink that stalls
    // about half the time.
    send_idle_pct = 6;
    recv_idle_pct = 51;
    run_directed();
    send_random_until(beats_sent + BEATS_PER_PHASE);
    wait_drained();

    // Phase two: the other way round, so the output register mostly waits
    // on the input side.
    send_idle_pct = 51;
    recv_idle_pct = 6;
    send_random_until(beats_sent + BEATS_PER_PHASE);
    wait_drained();

    // Phase three: full rate on both sides, opened by a long sink hold-off
    // during which the block must fill up and push back on its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    send_random_until(beats_sent + BEATS_PER_PHASE);
    wait_drained();

    $display("Run covered %0d input beats and %0d separated bins, %0d of them from silent sources,",
             beats_seen, bins_checked, silent_bins);
    $display("across sink-limited, source-limited and full-rate traffic with a %0d-cycle sink stall.",
             HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fdda_pkg.sv
rtl/fdda_if.sv
rtl/fdda_ram.sv
rtl/fdda_cmul.sv
rtl/freq_domain_demix_accumulator_unit.sv
rtl/fdda_chk.sv
tb/fdda_demix_checker.sv
tb/freq_domain_demix_accumulator_unit_tb.sv
